[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent, outside reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants of the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned PRIO_BITS = 8;
  localparam int unsigned TAG_BITS  = 32;
  localparam int unsigned CNT_BITS  = 5;

  typedef enum logic [0:0] {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    func_e                 func;
    logic [PRIO_BITS-1:0]  prio;
    logic [TAG_BITS-1:0]   tag;
  } in_t;

  typedef struct packed {
    status_e               status;
    logic [PRIO_BITS-1:0]  out_prio;
    logic [TAG_BITS-1:0]   out_tag;
    logic [CNT_BITS-1:0]   occupancy;
  } out_t;

  typedef struct packed {
    logic [PRIO_BITS-1:0]  prio;
    logic [TAG_BITS-1:0]   tag;
  } entry_t;

  // Broadcast to every cell: operation and the entry being pushed.
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t ent;
  } cell_cmd_t;

endpackage

[hdl/stable_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded stable priority queue built as a chain of sorted slot cells.
// ----------------------------------------------------------------------------
// Channel   Direction  Ports                  Transfer
// command   in         start_i, in_i, busy_o  start_i high while busy_o low
// result    out        done_o, res_o          done_o high, one cycle
//
// For every command all cells compare against the pushed
// priority in parallel and shift in the same edge; the result is registered
// and shows on res_o with done_o in the cycle after the transfer.
// busy_o stays low, so a command can be given in every cycle.
// Reset empties the queue by clearing the fill count; slot contents are left.
// The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stable_priority_queue_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  spq_pkg::in_t  in_i,
  output logic          done_o,
  output spq_pkg::out_t res_o
);

  logic [spq_pkg::CNT_BITS-1:0] cnt_q, cnt_d;
  logic                         done_q;
  spq_pkg::out_t                res_q, res_d;
  spq_pkg::cell_cmd_t           cmd;
  logic                         accept, is_pop, full, empty;

  spq_pkg::entry_t              ent_w   [spq_pkg::DEPTH];
  logic                         stays_w [spq_pkg::DEPTH];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign is_pop = (in_i.func == spq_pkg::FUNC_POP);
  assign full   = (cnt_q == spq_pkg::CNT_BITS'(spq_pkg::DEPTH));
  assign empty  = (cnt_q == '0);

  always_comb begin
    cmd.push     = accept && !is_pop && !full;
    cmd.pop      = accept && is_pop && !empty;
    cmd.ent.prio = in_i.prio;
    cmd.ent.tag  = in_i.tag;
  end

  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_ent, right_ent;
    logic            left_stays;

    if (i == 0) begin : g_head
      assign left_ent   = cmd.ent;
      assign left_stays = 1'b1;
    end else begin : g_body
      assign left_ent   = ent_w[i-1];
      assign left_stays = stays_w[i-1];
    end

    if (i == spq_pkg::DEPTH - 1) begin : g_tail
      assign right_ent = ent_w[i];
    end else begin : g_inner
      assign right_ent = ent_w[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occ_i        (spq_pkg::CNT_BITS'(i) < cnt_q),
      .left_i       (left_ent),
      .left_stays_i (left_stays),
      .right_i      (right_ent),
      .stays_o      (stays_w[i]),
      .ent_o        (ent_w[i])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd.push) begin
      cnt_d = cnt_q + spq_pkg::CNT_BITS'(1);
    end else if (cmd.pop) begin
      cnt_d = cnt_q - spq_pkg::CNT_BITS'(1);
    end
  end

  always_comb begin
    res_d.status    = spq_pkg::ST_OK;
    res_d.out_prio  = '0;
    res_d.out_tag   = '0;
    res_d.occupancy = cnt_d;
    if (is_pop) begin
      if (empty) begin
        res_d.status = spq_pkg::ST_EMPTY;
      end else begin
        res_d.out_prio = ent_w[0].prio;
        res_d.out_tag  = ent_w[0].tag;
      end
    end else if (full) begin
      res_d.status = spq_pkg::ST_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SPQ_ASSERT(a_cnt_bound, cnt_q <= spq_pkg::CNT_BITS'(spq_pkg::DEPTH), "fill count overflow")
  `SPQ_ASSERT(a_occ_match, !done_o || (res_o.occupancy == cnt_q), "occupancy mismatch")
  `SPQ_ASSERT(a_empty_occ, !(done_o && res_o.status == spq_pkg::ST_EMPTY) || (cnt_q == '0), "empty with entries")
  `SPQ_ASSERT_NEXT(a_push_inc, cmd.push, cnt_q == $past(cnt_q) + spq_pkg::CNT_BITS'(1), "push lost")

endmodule

[hdl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted shift chain: holds an entry, compares it against the
// pushed priority and shifts toward or away from the head.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                  clk_i,
  input  spq_pkg::cell_cmd_t    cmd_i,
  input  logic                  occ_i,
  input  spq_pkg::entry_t       left_i,
  input  logic                  left_stays_i,
  input  spq_pkg::entry_t       right_i,
  output logic                  stays_o,
  output spq_pkg::entry_t       ent_o
);

  spq_pkg::entry_t ent_q, ent_d;

  // Held entry is ahead of the new one when its priority is equal or lower.
  assign stays_o = occ_i && (ent_q.prio <= cmd_i.ent.prio);

  always_comb begin
    ent_d = ent_q;
    if (cmd_i.pop) begin
      ent_d = right_i;
    end else if (cmd_i.push && !stays_o) begin
      ent_d = left_stays_i ? cmd_i.ent : left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

[bench/spq_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spq_result_checker
// Watches the command and result channels of the stable priority queue,
// keeps its own sorted copy of the queue and compares every result.
// ----------------------------------------------------------------------------
module spq_result_checker
  import spq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  in_t         in_i,
  input  logic        done_o,
  input  out_t        res_o,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  entry_t      slots [DEPTH];
  int unsigned fill;
  out_t        owed_results [$];

  // Applies one command to the shadow queue and returns the result it gives.
  function automatic out_t queue_model_step(input in_t cmd);
    out_t        res;
    int unsigned pos;
    int unsigned i;
    res        = '0;
    res.status = ST_OK;
    if (cmd.func == FUNC_PUSH) begin
      if (fill >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // stable insert: behind every entry of equal or lower number
        pos = 0;
        while (pos < fill && slots[pos].prio <= cmd.prio) pos++;
        for (i = fill; i > pos; i--) slots[i] = slots[i-1];
        slots[pos].prio = cmd.prio;
        slots[pos].tag  = cmd.tag;
        fill++;
      end
    end else if (fill == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.out_prio = slots[0].prio;
      res.out_tag  = slots[0].tag;
      for (i = 1; i < fill; i++) slots[i-1] = slots[i];
      fill--;
    end
    res.occupancy = CNT_BITS'(fill);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      fill         = 0;
      owed_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // result of an earlier command: compare before queuing this edge's one
      if (done_o) begin
        if (owed_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          fail_count_o++;
        end else begin
          want = owed_results.pop_front();
          check_field("status", 64'(want.status), 64'(res_o.status));
          check_field("out_prio", 64'(want.out_prio), 64'(res_o.out_prio));
          check_field("out_tag", 64'(want.out_tag), 64'(res_o.out_tag));
          check_field("occupancy", 64'(want.occupancy), 64'(res_o.occupancy));
        end
      end
      if (start_i && !busy_o) owed_results.push_back(queue_model_step(in_i));
      pending_o = owed_results.size();
    end
  end

endmodule

[bench/stable_priority_queue_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_priority_queue_top_tb
// Drives push and pop commands into the queue: a directed pass over empty,
// full, extreme and tied priorities, then random traffic whose push rate
// swings so the queue runs between empty and full. A checker beside the
// block predicts every result.
// ----------------------------------------------------------------------------
module stable_priority_queue_top_tb;
  import spq_pkg::*;

  localparam int unsigned RANDOM_CMDS    = 1750;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 4;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  in_t         in_i;
  logic        done_o;
  out_t        res_o;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles;
  bit          gaps_on;
  int unsigned push_pct;

  stable_priority_queue_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .in_i    (in_i),
    .done_o  (done_o),
    .res_o   (res_o)
  );

  spq_result_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .in_i         (in_i),
    .done_o       (done_o),
    .res_o        (res_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Ends the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((start_i && !busy_o) || done_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Mostly small priorities so ties are common, with both extremes mixed in.
  function automatic in_t rand_cmd(input int unsigned push_chance);
    in_t cmd;
    int unsigned pick;
    cmd.func = ($urandom_range(99) < push_chance) ? FUNC_PUSH : FUNC_POP;
    pick     = $urandom_range(9);
    if (pick <= 5)       cmd.prio = PRIO_BITS'($urandom_range(3));
    else if (pick == 6)  cmd.prio = '0;
    else if (pick == 7)  cmd.prio = '1;
    else                 cmd.prio = PRIO_BITS'($urandom);
    cmd.tag  = TAG_BITS'($urandom);
    return cmd;
  endfunction

  // One command transfer; start_i stays high on return.
  task automatic issue(input in_t cmd);
    while (gaps_on && $urandom_range(99) < 20) begin
      start_i <= 1'b0;
      in_i    <= rand_cmd(50);
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= cmd;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic push_entry(input logic [PRIO_BITS-1:0] prio,
                            input logic [TAG_BITS-1:0] tag);
    in_t cmd;
    cmd.func = FUNC_PUSH;
    cmd.prio = prio;
    cmd.tag  = tag;
    issue(cmd);
  endtask

  task automatic pop_entry();
    in_t cmd;
    cmd      = rand_cmd(0);
    cmd.func = FUNC_POP;
    issue(cmd);
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    in_i        = '0;
    gaps_on     = 1'b1;
    push_pct    = 50;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pop, ties in arrival order, extremes, fill to full
    pop_entry();
    push_entry(8'd5, 32'h0000_0000);
    push_entry(8'd5, 32'hFFFF_FFFF);
    push_entry(8'd0, 32'h0000_0001);
    push_entry(8'd255, 32'h0000_0002);
    push_entry(8'd5, 32'h0000_0003);
    push_entry(8'd255, 32'h0000_0004);
    push_entry(8'd0, 32'h0000_0005);
    for (int unsigned k = 0; k < 9; k++) begin
      push_entry(PRIO_BITS'(k * 37), TAG_BITS'($urandom));
    end
    push_entry(8'd0, 32'hA5A5_A5A5);  // rejected, queue full
    repeat (5) pop_entry();

    // random: push rate changes in bursts, one long stretch without gaps
    for (int unsigned n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      gaps_on = !(n >= 700 && n < 1000);
      issue(rand_cmd(push_pct));
    end
    start_i <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
